// ===== rtl/core/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared constants and width helpers for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 16;
  localparam int unsigned PAGE_BITS_DEF  = 16;

  localparam int unsigned CFG_W       = 5;
  localparam int unsigned FRAME_IDX_W = 4;
  localparam int unsigned CNT_W       = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  // Bits for a frame index or an age rank (both range over 0..max-1).
  function automatic int unsigned idx_width(input int unsigned max_frames);
    int unsigned w;
    w = $clog2(max_frames);
    return (w < 1) ? 1 : w;
  endfunction

  // Bits for the clamped in-use count, also wide enough for the raw register.
  function automatic int unsigned num_width(input int unsigned max_frames);
    int unsigned w;
    w = $clog2(max_frames + 1);
    return (w < CFG_W) ? CFG_W : w;
  endfunction

  // Scan record handed from cell to cell.
  function automatic int unsigned carry_width(input int unsigned iw,
                                              input int unsigned pw);
    return 3 + 5 * iw + pw;
  endfunction

  // Update command broadcast to all cells.
  function automatic int unsigned upd_width(input int unsigned iw,
                                            input int unsigned pw);
    return 2 + 2 * iw + pw;
  endfunction

endpackage

// ===== rtl/core/lrupr_if.sv =====
// ----------------------------------------------------------------------------
// lrupr_if
// Request and response channels of the LRU page replacement block.
// ----------------------------------------------------------------------------
interface lrupr_req_if #(
  parameter int unsigned PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if #(
  parameter int unsigned PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) ();
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic [lrupr_pkg::FRAME_IDX_W-1:0]      frame_index;
  logic                                   evicted_valid;
  logic [PAGE_BITS-1:0]                   evicted_page;
  logic [lrupr_pkg::CNT_W-1:0]            hit_count;
  logic [lrupr_pkg::CNT_W-1:0]            fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output hit_count, output fault_count,
                  input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input hit_count, input fault_count,
                  output ready);
endinterface

// ===== rtl/core/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// lrupr_cell
// One frame of the table: page, valid bit and age rank, plus one stage of
// the lookup scan that runs down the row of cells.
// ----------------------------------------------------------------------------
module lrupr_cell #(
  parameter int unsigned MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
  parameter int unsigned CELL_IDX   = 0,
  parameter int unsigned IW         = lrupr_pkg::idx_width(MAX_FRAMES),
  parameter int unsigned NW         = lrupr_pkg::num_width(MAX_FRAMES),
  parameter int unsigned CW         = lrupr_pkg::carry_width(IW, PAGE_BITS),
  parameter int unsigned UW         = lrupr_pkg::upd_width(IW, PAGE_BITS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [PAGE_BITS-1:0] req_page_i,
  input  logic [NW-1:0]        num_i,
  input  logic [CW-1:0]        carry_i,
  output logic [CW-1:0]        carry_o,
  input  logic [UW-1:0]        upd_i
);
  import lrupr_pkg::*;

  typedef struct packed {
    logic                 hit_f;
    logic [IW-1:0]        hit_idx;
    logic [IW-1:0]        hit_age;
    logic                 empty_f;
    logic [IW-1:0]        empty_idx;
    logic                 max_f;
    logic [IW-1:0]        max_idx;
    logic [IW-1:0]        max_age;
    logic [PAGE_BITS-1:0] max_page;
  } carry_t;

  typedef struct packed {
    logic                 upd;
    logic                 was_valid;
    logic [IW-1:0]        idx;
    logic [IW-1:0]        old_age;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

  localparam logic [IW-1:0] MY_IDX  = IW'(CELL_IDX);
  localparam logic [IW-1:0] AGE_MAX = IW'(MAX_FRAMES - 1);

  logic                 valid_q, valid_d;
  logic [IW-1:0]        age_q, age_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  carry_t               carry_in, carry_d, carry_q;
  upd_t                 upd;
  logic                 in_use;

  assign carry_in = carry_t'(carry_i);
  assign upd      = upd_t'(upd_i);
  assign in_use   = NW'(CELL_IDX) < num_i;
  assign carry_o  = CW'(carry_q);

  // Fold this frame into the running scan record.
  always_comb begin
    carry_d = carry_in;
    if (in_use) begin
      if (!carry_in.hit_f && valid_q && (page_q == req_page_i)) begin
        carry_d.hit_f   = 1'b1;
        carry_d.hit_idx = MY_IDX;
        carry_d.hit_age = age_q;
      end
      if (!carry_in.empty_f && !valid_q) begin
        carry_d.empty_f   = 1'b1;
        carry_d.empty_idx = MY_IDX;
      end
      if (!carry_in.max_f || (age_q > carry_in.max_age)) begin
        carry_d.max_f    = 1'b1;
        carry_d.max_idx  = MY_IDX;
        carry_d.max_age  = age_q;
        carry_d.max_page = page_q;
      end
    end
  end

  // Apply the broadcast update: the chosen frame goes to most recent; valid
  // frames more recent than its old rank (all, if it was empty) step back one.
  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    page_d  = page_q;
    if (upd.upd) begin
      if (upd.idx == MY_IDX) begin
        valid_d = 1'b1;
        age_d   = '0;
        page_d  = upd.page;
      end else if (valid_q && (!upd.was_valid || (age_q < upd.old_age)) &&
                   (age_q < AGE_MAX)) begin
        age_d = age_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    carry_q <= carry_d;
  end

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative frame table with least-recently-used replacement, built
// as a row of frame cells with a lookup scan that moves one cell per cycle.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  req_i     in   valid / ready    page_number
//  rsp_o     out  valid / ready    hit, frame_index, evicted_valid,
//                                  evicted_page, hit_count, fault_count
//  cfg       in   cfg_we_i         cfg_wdata_i = frames_in_use
//
//  For each request the scan record walks the row of cells one frame per cycle,
//  then the decide step applies the update to all cells.
//  The response register lets the next request enter while a response waits.
//  Reset empties every frame, clears ages and counts, frames_in_use = 16.
//  A stalled response holds the block in its update step until taken.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata_i,
  lrupr_req_if.sink                   req_i,
  lrupr_rsp_if.source                 rsp_o
);
  import lrupr_pkg::*;

  localparam int unsigned IW = idx_width(MAX_FRAMES);
  localparam int unsigned NW = num_width(MAX_FRAMES);
  localparam int unsigned CW = carry_width(IW, PAGE_BITS);
  localparam int unsigned UW = upd_width(IW, PAGE_BITS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  typedef struct packed {
    logic                 hit_f;
    logic [IW-1:0]        hit_idx;
    logic [IW-1:0]        hit_age;
    logic                 empty_f;
    logic [IW-1:0]        empty_idx;
    logic                 max_f;
    logic [IW-1:0]        max_idx;
    logic [IW-1:0]        max_age;
    logic [PAGE_BITS-1:0] max_page;
  } carry_t;

  typedef struct packed {
    logic                 upd;
    logic                 was_valid;
    logic [IW-1:0]        idx;
    logic [IW-1:0]        old_age;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

  logic [1:0]           state_q, state_d;
  logic [IW-1:0]        scan_q, scan_d;
  logic [PAGE_BITS-1:0] req_page_q;
  logic [CFG_W-1:0]     frames_q;
  logic [NW-1:0]        cfg_ext, num;
  logic [CNT_W-1:0]     hits_q, faults_q, hits_d, faults_d;

  logic [CW-1:0]        chain [MAX_FRAMES+1];
  carry_t               res;
  upd_t                 upd;
  logic                 accept, done;

  logic                 dec_hit, dec_evict;
  logic [IW-1:0]        dec_idx;
  logic [IW+FRAME_IDX_W-1:0] idx_ext;

  logic                      out_valid_q;
  logic                      out_hit_q, out_ev_valid_q;
  logic [FRAME_IDX_W-1:0]    out_idx_q;
  logic [PAGE_BITS-1:0]      out_ev_page_q;
  logic [CNT_W-1:0]          out_hits_q, out_faults_q;

  // Clamp the in-use count to 1..MAX_FRAMES.
  assign cfg_ext = NW'(frames_q);
  always_comb begin
    if (frames_q == '0) begin
      num = NW'(1);
    end else if (cfg_ext > NW'(MAX_FRAMES)) begin
      num = NW'(MAX_FRAMES);
    end else begin
      num = cfg_ext;
    end
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .CELL_IDX   (g),
      .IW         (IW),
      .NW         (NW),
      .CW         (CW),
      .UW         (UW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .req_page_i (req_page_q),
      .num_i      (num),
      .carry_i    (chain[g]),
      .carry_o    (chain[g+1]),
      .upd_i      (UW'(upd))
    );
  end

  assign res = carry_t'(chain[MAX_FRAMES]);

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign done        = (state_q == S_DECIDE) && (!out_valid_q || rsp_o.ready);

  // Pick the frame: hit first, then the lowest empty frame, else the oldest.
  always_comb begin
    dec_hit       = res.hit_f;
    dec_evict     = 1'b0;
    upd.upd       = done;
    upd.page      = req_page_q;
    upd.was_valid = 1'b1;
    upd.old_age   = res.max_age;
    dec_idx       = res.max_idx;
    if (res.hit_f) begin
      dec_idx     = res.hit_idx;
      upd.old_age = res.hit_age;
    end else if (res.empty_f) begin
      dec_idx       = res.empty_idx;
      upd.was_valid = 1'b0;
    end else begin
      dec_evict = 1'b1;
    end
    upd.idx = dec_idx;
  end

  assign idx_ext = {{FRAME_IDX_W{1'b0}}, dec_idx};

  always_comb begin
    hits_d   = hits_q;
    faults_d = faults_q;
    if (dec_hit) begin
      if (hits_q != '1) begin
        hits_d = hits_q + 1'b1;
      end
    end else if (faults_q != '1) begin
      faults_d = faults_q + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          scan_d  = '0;
        end
      end
      S_SCAN: begin
        if (scan_q == IW'(MAX_FRAMES - 1)) begin
          state_d = S_DECIDE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_DECIDE: begin
        if (done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      frames_q    <= FRAMES_RESET;
      hits_q      <= '0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      if (cfg_we_i) begin
        frames_q <= cfg_wdata_i;
      end
      if (done) begin
        hits_q      <= hits_d;
        faults_q    <= faults_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_page_q <= req_i.page_number;
    end
    if (done) begin
      out_hit_q      <= dec_hit;
      out_idx_q      <= idx_ext[FRAME_IDX_W-1:0];
      out_ev_valid_q <= dec_evict;
      out_ev_page_q  <= dec_evict ? res.max_page : '0;
      out_hits_q     <= hits_d;
      out_faults_q   <= faults_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.frame_index   = out_idx_q;
  assign rsp_o.evicted_valid = out_ev_valid_q;
  assign rsp_o.evicted_page  = out_ev_page_q;
  assign rsp_o.hit_count     = out_hits_q;
  assign rsp_o.fault_count   = out_faults_q;

endmodule
